// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared macros for concurrent assertions on a clocked, reset-qualified design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising clock edge out of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Checks that a condition never holds at a rising clock edge out of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

// ===== design/tfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Telegram frame receiver package
// Types, codes and the CRC-16/MODBUS byte update shared by the design files.
// ----------------------------------------------------------------------------
`default_nettype none

package tfr_pkg;

	localparam int unsigned ADDR_W = 4;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] MAX_LEN_RESET = 16'd512;
	localparam logic [16:0] FRAME_OVERHEAD = 17'd7;

	typedef enum logic [1:0] {
		REG_HEAD = 2'd0,
		REG_SYNC = 2'd1,
		REG_END  = 2'd2,
		REG_MAXLEN = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_HUNT   = 3'd0,
		PH_LEN_LO = 3'd1,
		PH_LEN_HI = 3'd2,
		PH_SYNC   = 3'd3,
		PH_MSG    = 3'd4,
		PH_CRC_LO = 3'd5,
		PH_CRC_HI = 3'd6,
		PH_END    = 3'd7
	} phase_t;

	typedef enum logic [2:0] {
		ERR_NONE = 3'd0,
		ERR_SYNC = 3'd1,
		ERR_LEN  = 3'd2,
		ERR_END  = 3'd3,
		ERR_CRC  = 3'd4
	} err_t;

	typedef struct packed {
		logic [7:0]  head_marker;
		logic [7:0]  sync_marker;
		logic [7:0]  end_marker;
		logic [15:0] max_length;
	} cfg_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
		input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== design/tfr_channels.sv =====
// ----------------------------------------------------------------------------
// Telegram frame receiver channels
// Valid/ready channels for received bytes and for per-byte results.
// ----------------------------------------------------------------------------
`default_nettype none

interface tfr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface tfr_result_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        message_byte;
	logic        frame_end;
	logic        frame_good;
	logic [2:0]  error_code;
	logic [16:0] frame_length;

	modport source (output valid, output out_byte, output message_byte,
		output frame_end, output frame_good, output error_code,
		output frame_length, input ready);
	modport sink (input valid, input out_byte, input message_byte,
		input frame_end, input frame_good, input error_code,
		input frame_length, output ready);
endinterface

`default_nettype wire

// ===== design/tfr_regs.sv =====
// ----------------------------------------------------------------------------
// Telegram frame receiver register file
// APB-style configuration registers for the frame markers and length limit.
// ----------------------------------------------------------------------------
`default_nettype none

module tfr_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [tfr_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	output tfr_pkg::cfg_t                   cfg
);
	import tfr_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx = reg_idx_t'(paddr[3:2]);
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.head_marker <= 8'h00;
			cfg_q.sync_marker <= 8'h00;
			cfg_q.end_marker <= 8'h00;
			cfg_q.max_length <= MAX_LEN_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_HEAD:   cfg_q.head_marker <= pwdata[7:0];
				REG_SYNC:   cfg_q.sync_marker <= pwdata[7:0];
				REG_END:    cfg_q.end_marker <= pwdata[7:0];
				REG_MAXLEN: cfg_q.max_length <= pwdata[15:0];
				default:    cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_HEAD:   prdata = {24'h0, cfg_q.head_marker};
			REG_SYNC:   prdata = {24'h0, cfg_q.sync_marker};
			REG_END:    prdata = {24'h0, cfg_q.end_marker};
			REG_MAXLEN: prdata = {16'h0, cfg_q.max_length};
			default:    prdata = 32'h0;
		endcase
	end

endmodule

`default_nettype wire

// ===== design/telegram_frame_receiver_top.sv =====
// ----------------------------------------------------------------------------
// Telegram frame receiver
// Hunts for framed telegrams in a byte stream, checks sync, length, end byte
// and CRC-16/MODBUS, and echoes every byte with its message flag and verdict.
// A byte accepted into the input register has its result registered in the
// output register and offered on the result channel.
// Throughput: one byte per cycle while the result channel is ready; the path
// between registers is one eight-step CRC byte update plus frame-state decode.
// Reset: asynchronous; phase returns to hunting, markers to zero, max length
// to 512. Nothing needs a clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module telegram_frame_receiver_top (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	tfr_byte_if.sink                        rx,
	tfr_result_if.source                    res,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [tfr_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import tfr_pkg::*;

	cfg_t cfg;

	logic        v_s1;
	logic [7:0]  byte_s1;
	logic        v_s2;
	logic [7:0]  byte_s2;
	logic        msg_s2;
	logic        end_s2;
	logic        good_s2;
	err_t        err_s2;
	logic [16:0] flen_s2;

	phase_t      phase_q;
	phase_t      phase_d;
	logic [15:0] len_q;
	logic [15:0] len_d;
	logic [15:0] left_q;
	logic [15:0] left_d;
	logic [15:0] crc_q;
	logic [15:0] crc_d;
	logic [7:0]  crc_lo_q;
	logic [7:0]  crc_lo_d;
	logic        crc_ok_q;
	logic        crc_ok_d;

	logic        msg;
	logic        fend;
	logic        good;
	err_t        err;
	logic [16:0] flen;
	logic        adv;

	tfr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign adv = v_s1 && (!v_s2 || res.ready);
	assign rx.ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rx.valid && rx.ready) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				v_s2 <= 1'b1;
			end else if (res.ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
		if (adv) begin
			byte_s2 <= byte_s1;
			msg_s2 <= msg;
			end_s2 <= fend;
			good_s2 <= good;
			err_s2 <= err;
			flen_s2 <= flen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			len_q <= 16'h0;
			left_q <= 16'h0;
			crc_q <= CRC_INIT;
			crc_lo_q <= 8'h0;
			crc_ok_q <= 1'b0;
		end else if (adv) begin
			phase_q <= phase_d;
			len_q <= len_d;
			left_q <= left_d;
			crc_q <= crc_d;
			crc_lo_q <= crc_lo_d;
			crc_ok_q <= crc_ok_d;
		end
	end

	// Next frame state for the byte in the input register.
	always_comb begin
		phase_d = phase_q;
		len_d = len_q;
		left_d = left_q;
		crc_d = crc_q;
		crc_lo_d = crc_lo_q;
		crc_ok_d = crc_ok_q;
		case (phase_q)
			PH_HUNT: begin
				if (byte_s1 == cfg.head_marker) begin
					crc_d = CRC_INIT;
					len_d = 16'h0;
					left_d = 16'h0;
					crc_lo_d = 8'h0;
					crc_ok_d = 1'b0;
					phase_d = PH_LEN_LO;
				end
			end
			PH_LEN_LO: begin
				len_d = {8'h00, byte_s1};
				phase_d = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				len_d = {byte_s1, len_q[7:0]};
				phase_d = PH_SYNC;
			end
			PH_SYNC: begin
				if (byte_s1 != cfg.sync_marker || len_q > cfg.max_length) begin
					phase_d = PH_HUNT;
				end else begin
					left_d = len_q;
					phase_d = (len_q == 16'h0) ? PH_CRC_LO : PH_MSG;
				end
			end
			PH_MSG: begin
				crc_d = crc16_byte(crc_q, byte_s1);
				left_d = left_q - 16'd1;
				if (left_q == 16'd1) begin
					phase_d = PH_CRC_LO;
				end
			end
			PH_CRC_LO: begin
				crc_lo_d = byte_s1;
				phase_d = PH_CRC_HI;
			end
			PH_CRC_HI: begin
				crc_ok_d = ({byte_s1, crc_lo_q} == crc_q);
				phase_d = PH_END;
			end
			PH_END: begin
				phase_d = PH_HUNT;
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	// Result fields for the byte in the input register.
	always_comb begin
		msg = 1'b0;
		fend = 1'b0;
		good = 1'b0;
		err = ERR_NONE;
		flen = 17'h0;
		case (phase_q)
			PH_SYNC: begin
				if (byte_s1 != cfg.sync_marker) begin
					fend = 1'b1;
					err = ERR_SYNC;
				end else if (len_q > cfg.max_length) begin
					fend = 1'b1;
					err = ERR_LEN;
				end
			end
			PH_MSG: begin
				msg = 1'b1;
			end
			PH_END: begin
				fend = 1'b1;
				if (byte_s1 != cfg.end_marker) begin
					err = ERR_END;
				end else if (!crc_ok_q) begin
					err = ERR_CRC;
				end else begin
					good = 1'b1;
					flen = {1'b0, len_q} + FRAME_OVERHEAD;
				end
			end
			default: begin
				msg = 1'b0;
			end
		endcase
	end

	assign res.valid = v_s2;
	assign res.out_byte = byte_s2;
	assign res.message_byte = msg_s2;
	assign res.frame_end = end_s2;
	assign res.frame_good = good_s2;
	assign res.error_code = err_s2;
	assign res.frame_length = flen_s2;

	`include "assert_macros.svh"

	`ASSERT_CLK(a_good_is_clean_end, clk, arst_n,
		res.valid && res.frame_good |->
			res.frame_end && res.error_code == ERR_NONE && res.frame_length != 17'h0,
		"Good frame without a clean frame end.")
	`ASSERT_NEVER(a_msg_not_end, clk, arst_n,
		res.valid && res.message_byte && res.frame_end,
		"Message byte flagged as frame end.")
	`ASSERT_CLK(a_end_returns_to_hunt, clk, arst_n,
		adv && fend |=> phase_q == PH_HUNT,
		"Frame end did not return to hunting.")

endmodule

`default_nettype wire

// ===== dv/tfr_checker.sv =====
// ----------------------------------------------------------------------------
// Telegram frame receiver checker
// Watches the byte, result and register channels, predicts the result of each
// received byte from its own model of the frame parser and CRC-16/MODBUS,
// and compares every result transaction field by field in arrival order.
// ----------------------------------------------------------------------------
module tfr_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	tfr_byte_if                        rx_mon,
	tfr_result_if                      res_mon,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic                       pready,
	input  logic [tfr_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output int                         mismatches,
	output int                         outstanding,
	output int                         frames_good,
	output int                         frames_bad
);
	timeunit 1ns;
	timeprecision 1ps;
	import tfr_pkg::*;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        message_byte;
		logic        frame_end;
		logic        frame_good;
		err_t        error_code;
		logic [16:0] frame_length;
	} byte_verdict_t;

	cfg_t          cfg_q;
	phase_t        ph;
	logic [15:0]   len_q;
	logic [15:0]   left_q;
	logic [15:0]   crc_q;
	logic [7:0]    crc_lo_q;
	logic          crc_ok_q;
	byte_verdict_t verdict_q[$];
	byte_verdict_t want;
	int            err_total;
	int            good_total;
	int            bad_total;

	function automatic logic [15:0] modbus_crc_step(input logic [15:0] acc,
		input logic [7:0] d);
		logic [15:0] r;
		r = acc;
		for (int i = 0; i < 8; i++) begin
			r = {1'b0, r[15:1]} ^ ((r[0] ^ d[i]) ? 16'hA001 : 16'h0000);
		end
		return r;
	endfunction

	function automatic byte_verdict_t next_verdict(input logic [7:0] b);
		byte_verdict_t v;
		v = '0;
		v.out_byte = b;
		v.error_code = ERR_NONE;
		case (ph)
			PH_HUNT: begin
				if (b == cfg_q.head_marker) begin
					crc_q = CRC_INIT;
					len_q = '0;
					left_q = '0;
					crc_lo_q = '0;
					crc_ok_q = 1'b0;
					ph = PH_LEN_LO;
				end
			end
			PH_LEN_LO: begin
				len_q = {8'h00, b};
				ph = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				len_q[15:8] = b;
				ph = PH_SYNC;
			end
			PH_SYNC: begin
				if (b != cfg_q.sync_marker) begin
					v.frame_end = 1'b1;
					v.error_code = ERR_SYNC;
					ph = PH_HUNT;
				end else if (len_q > cfg_q.max_length) begin
					v.frame_end = 1'b1;
					v.error_code = ERR_LEN;
					ph = PH_HUNT;
				end else begin
					left_q = len_q;
					ph = (len_q == 16'd0) ? PH_CRC_LO : PH_MSG;
				end
			end
			PH_MSG: begin
				v.message_byte = 1'b1;
				crc_q = modbus_crc_step(crc_q, b);
				left_q = left_q - 16'd1;
				if (left_q == 16'd0) begin
					ph = PH_CRC_LO;
				end
			end
			PH_CRC_LO: begin
				crc_lo_q = b;
				ph = PH_CRC_HI;
			end
			PH_CRC_HI: begin
				crc_ok_q = ({b, crc_lo_q} == crc_q);
				ph = PH_END;
			end
			default: begin
				v.frame_end = 1'b1;
				if (b != cfg_q.end_marker) begin
					v.error_code = ERR_END;
				end else if (!crc_ok_q) begin
					v.error_code = ERR_CRC;
				end else begin
					v.frame_good = 1'b1;
					v.frame_length = {1'b0, len_q} + FRAME_OVERHEAD;
				end
				ph = PH_HUNT;
			end
		endcase
		return v;
	endfunction

	task automatic compare_field(input string fname, input logic [16:0] exp_val,
		input logic [16:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s: expected %0d, actual %0d", fname, exp_val, act_val);
			err_total++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{8'h00, 8'h00, 8'h00, MAX_LEN_RESET};
			ph <= PH_HUNT;
			len_q <= '0;
			left_q <= '0;
			crc_q <= CRC_INIT;
			crc_lo_q <= '0;
			crc_ok_q <= 1'b0;
			verdict_q.delete();
			err_total = 0;
			good_total = 0;
			bad_total = 0;
			mismatches <= 0;
			outstanding <= 0;
			frames_good <= 0;
			frames_bad <= 0;
		end else begin
			if (res_mon.valid && res_mon.ready) begin
				if (verdict_q.size() == 0) begin
					$error("result transaction with no byte pending: out_byte %0d",
						res_mon.out_byte);
					err_total++;
				end else begin
					want = verdict_q.pop_front();
					compare_field("out_byte", 17'(want.out_byte), 17'(res_mon.out_byte));
					compare_field("message_byte", 17'(want.message_byte),
						17'(res_mon.message_byte));
					compare_field("frame_end", 17'(want.frame_end), 17'(res_mon.frame_end));
					compare_field("frame_good", 17'(want.frame_good),
						17'(res_mon.frame_good));
					compare_field("error_code", 17'(want.error_code),
						17'(res_mon.error_code));
					compare_field("frame_length", want.frame_length, res_mon.frame_length);
					if (want.frame_end) begin
						if (want.frame_good) begin
							good_total++;
						end else begin
							bad_total++;
						end
					end
				end
			end
			if (rx_mon.valid && rx_mon.ready) begin
				verdict_q.push_back(next_verdict(rx_mon.rx_byte));
			end
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_HEAD:   cfg_q.head_marker <= pwdata[7:0];
					REG_SYNC:   cfg_q.sync_marker <= pwdata[7:0];
					REG_END:    cfg_q.end_marker <= pwdata[7:0];
					REG_MAXLEN: cfg_q.max_length <= pwdata[15:0];
					default: begin
					end
				endcase
			end
			mismatches <= err_total;
			outstanding <= verdict_q.size();
			frames_good <= good_total;
			frames_bad <= bad_total;
		end
	end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Telegram frame receiver testbench
// Drives directed and random byte streams of well-formed and damaged frames
// through the receiver under several marker and length-limit settings, with
// random gaps and result back-pressure; a checker predicts every result.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import tfr_pkg::*;

	typedef enum int {
		FL_NONE,
		FL_SYNC,
		FL_LEN,
		FL_CRC,
		FL_END,
		FL_END_CRC
	} frame_flaw_t;

	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_SETTINGS = 6;
	localparam int FRAMED_PER_SETTING = 125;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	int                mismatches;
	int                outstanding;
	int                frames_good;
	int                frames_bad;
	cfg_t              cfg;
	bit                quiet;
	int unsigned       stall_left;
	int                idle_cycles;
	int                bytes_sent;
	int                framed_sent;
	int                settings_used;

	tfr_byte_if   rx_ch ();
	tfr_result_if res_ch ();

	telegram_frame_receiver_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	tfr_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_mon      (rx_ch),
		.res_mon     (res_ch),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.frames_good (frames_good),
		.frames_bad  (frames_bad)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	always @(posedge clk) begin
		if (stall_left != 0) begin
			res_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 3) == 0) begin
			res_ch.ready <= 1'b0;
			stall_left <= pick_gap();
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic put_byte(input logic [7:0] b, input bit framed);
		int unsigned gap;
		gap = quiet ? 0 : pick_gap();
		if (gap != 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (!rx_ch.ready);
		bytes_sent++;
		if (framed) begin
			framed_sent++;
		end
	endtask

	task automatic settle();
		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic set_config(input cfg_t c);
		apb_write(REG_HEAD, {24'($urandom), c.head_marker});
		apb_write(REG_SYNC, {24'($urandom), c.sync_marker});
		apb_write(REG_END, {24'($urandom), c.end_marker});
		apb_write(REG_MAXLEN, {16'($urandom), c.max_length});
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cfg = c;
		settings_used++;
	endtask

	task automatic send_frame(input int unsigned len, input frame_flaw_t flaw,
		input bit embed_head);
		logic [15:0] crc;
		logic [15:0] lf;
		logic [7:0]  d;
		lf = 16'(len);
		put_byte(cfg.head_marker, 1'b1);
		put_byte(lf[7:0], 1'b1);
		put_byte(lf[15:8], 1'b1);
		if (flaw == FL_SYNC) begin
			put_byte(cfg.sync_marker ^ 8'($urandom_range(1, 255)), 1'b1);
			return;
		end
		put_byte(cfg.sync_marker, 1'b1);
		if (flaw == FL_LEN) begin
			return;
		end
		crc = CRC_INIT;
		for (int i = 0; i < int'(len); i++) begin
			if ((embed_head && i == 0) || $urandom_range(0, 7) == 0) begin
				d = cfg.head_marker;
			end else begin
				d = 8'($urandom);
			end
			crc = crc16_byte(crc, d);
			put_byte(d, 1'b1);
		end
		if (flaw == FL_CRC || flaw == FL_END_CRC) begin
			crc ^= 16'($urandom_range(1, 65535));
		end
		put_byte(crc[7:0], 1'b1);
		put_byte(crc[15:8], 1'b1);
		if (flaw == FL_END || flaw == FL_END_CRC) begin
			put_byte(cfg.end_marker ^ 8'($urandom_range(1, 255)), 1'b1);
		end else begin
			put_byte(cfg.end_marker, 1'b1);
		end
	endtask

	function automatic cfg_t random_settings();
		cfg_t c;
		c.head_marker = 8'($urandom);
		c.sync_marker = 8'($urandom);
		c.end_marker = 8'($urandom);
		case ($urandom_range(0, 9))
			0: c.max_length = 16'd0;
			1: c.max_length = 16'hFFFF;
			2: c.max_length = MAX_LEN_RESET;
			default: c.max_length = 16'($urandom_range(1, 30));
		endcase
		return c;
	endfunction

	task automatic send_random_frame();
		frame_flaw_t flaw;
		int unsigned r;
		int unsigned len;
		int unsigned cap;
		quiet = ($urandom_range(0, 4) == 0);
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 3)) put_byte(8'($urandom), 1'b0);
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			flaw = FL_NONE;
		end else if (r < 68) begin
			flaw = FL_SYNC;
		end else if (r < 76) begin
			flaw = FL_LEN;
		end else if (r < 84) begin
			flaw = FL_CRC;
		end else if (r < 92) begin
			flaw = FL_END;
		end else begin
			flaw = FL_END_CRC;
		end
		if (flaw == FL_LEN && cfg.max_length == 16'hFFFF) begin
			flaw = FL_SYNC;
		end
		cap = (cfg.max_length < 24) ? cfg.max_length : 24;
		if (flaw == FL_SYNC) begin
			len = $urandom_range(0, 65535);
		end else if (flaw == FL_LEN) begin
			len = ($urandom_range(0, 1) == 0) ? cfg.max_length + 1 :
				$urandom_range(cfg.max_length + 1, 65535);
		end else if (cfg.max_length >= 300 && $urandom_range(0, 39) == 0) begin
			len = $urandom_range(256, 300);
		end else if ($urandom_range(0, 4) == 0) begin
			len = cap;
		end else begin
			len = $urandom_range(0, cap);
		end
		send_frame(len, flaw, 1'b0);
	endtask

	initial begin
		int target;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = '0;
		res_ch.ready = 1'b0;
		quiet = 1'b0;
		stall_left = 0;
		idle_cycles = 0;
		bytes_sent = 0;
		framed_sent = 0;
		settings_used = 0;
		cfg = '{8'h00, 8'h00, 8'h00, MAX_LEN_RESET};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		put_byte(8'hA5, 1'b0);
		put_byte(8'hFF, 1'b0);
		send_frame(0, FL_NONE, 1'b0);
		send_frame(2, FL_NONE, 1'b1);
		send_frame(3, FL_SYNC, 1'b0);
		send_frame(513, FL_LEN, 1'b0);
		send_frame(1, FL_END_CRC, 1'b0);
		send_frame(1, FL_CRC, 1'b0);
		send_frame(2, FL_END, 1'b0);

		settle();
		set_config('{8'hFF, 8'hFF, 8'hFF, 16'd0});
		send_frame(0, FL_NONE, 1'b0);
		send_frame(1, FL_LEN, 1'b0);
		send_frame(0, FL_CRC, 1'b0);

		settle();
		set_config('{8'h00, 8'h00, 8'h00, 16'hFFFF});
		send_frame(16'hFFFF, FL_SYNC, 1'b0);
		send_frame(1, FL_NONE, 1'b1);

		for (int s = 0; s < RANDOM_SETTINGS; s++) begin
			settle();
			set_config(random_settings());
			target = framed_sent + FRAMED_PER_SETTING;
			while (framed_sent < target) send_random_frame();
		end

		quiet = 1'b0;
		settle();
		repeat (4) @(posedge clk);
		$display("Sent %0d bytes, %0d of them in frames, under %0d register settings.",
			bytes_sent, framed_sent, settings_used + 1);
		$display("Frames closed: %0d good, %0d rejected with an error code.",
			frames_good, frames_bad);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
